@@ src/assert_macros.svh @@
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/scbd_pkg.sv @@
package scbd_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_VIEW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_VIEW_RIGHT  = 3'd1;
    localparam logic [2:0] CFG_VIEW_TOP    = 3'd2;
    localparam logic [2:0] CFG_VIEW_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_VIEW_ROWS   = 3'd4;
    localparam logic [2:0] CFG_DEST_BASE   = 3'd5;
    localparam logic [2:0] CFG_DEST_SEG    = 3'd6;

    // Register reset values
    localparam logic [15:0] VIEW_LEFT_RST   = 16'd0;
    localparam logic [15:0] VIEW_RIGHT_RST  = 16'd40;
    localparam logic [15:0] VIEW_TOP_RST    = 16'd0;
    localparam logic [15:0] VIEW_BOTTOM_RST = 16'd200;
    localparam logic [15:0] VIEW_ROWS_RST   = 16'd200;
    localparam logic [15:0] DEST_BASE_RST   = 16'd0;
    localparam logic [15:0] DEST_SEG_RST    = 16'd0;

    // Byte pitch between destination rows
    localparam logic [15:0] ROW_PITCH = 16'd40;
    // Upper bound (exclusive) on rows for the clip verdict
    localparam logic signed [15:0] CLIP_ROW_LIMIT = 16'sd100;
    // Rounding bias and mask for snapping x to a cell
    localparam logic [15:0] SNAP_BIAS = 16'd4;
    localparam logic [15:0] SNAP_MASK = 16'hfff8;

    typedef struct packed {
        logic [15:0] view_left;
        logic [15:0] view_right;
        logic [15:0] view_top;
        logic [15:0] view_bottom;
        logic [15:0] view_rows;
        logic [15:0] dest_base_offset;
        logic [15:0] dest_segment;
    } view_cfg_t;

    typedef struct packed {
        logic               visible;
        logic               right_anchor;
        logic               snap_to_cell;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] hot_x;
        logic signed [15:0] hot_y;
        logic [15:0]        sprite_width;
        logic signed [15:0] sprite_height;
        logic [15:0]        src_base_offset;
        logic [15:0]        src_segment;
    } sprite_in_t;

    typedef struct packed {
        logic        drawn;
        logic [15:0] src_offset;
        logic [15:0] src_seg_out;
        logic [15:0] dst_offset;
        logic [15:0] dst_seg_out;
        logic [7:0]  full_cols;
        logic [15:0] cols_drawn;
        logic [15:0] rows_drawn;
        logic [2:0]  sub_shift;
        logic [1:0]  clip_flags;
        logic        clip_nonempty;
    } blit_desc_t;

endpackage

@@ src/scbd_cfg_regs.sv @@
module scbd_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output scbd_pkg::view_cfg_t cfg
);

    scbd_pkg::view_cfg_t cfg_reg;
    scbd_pkg::view_cfg_t cfg_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scbd_pkg::CFG_VIEW_LEFT:   cfg_next.view_left        = cfg_data;
                scbd_pkg::CFG_VIEW_RIGHT:  cfg_next.view_right       = cfg_data;
                scbd_pkg::CFG_VIEW_TOP:    cfg_next.view_top         = cfg_data;
                scbd_pkg::CFG_VIEW_BOTTOM: cfg_next.view_bottom      = cfg_data;
                scbd_pkg::CFG_VIEW_ROWS:   cfg_next.view_rows        = cfg_data;
                scbd_pkg::CFG_DEST_BASE:   cfg_next.dest_base_offset = cfg_data;
                scbd_pkg::CFG_DEST_SEG:    cfg_next.dest_segment     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_left        <= scbd_pkg::VIEW_LEFT_RST;
            cfg_reg.view_right       <= scbd_pkg::VIEW_RIGHT_RST;
            cfg_reg.view_top         <= scbd_pkg::VIEW_TOP_RST;
            cfg_reg.view_bottom      <= scbd_pkg::VIEW_BOTTOM_RST;
            cfg_reg.view_rows        <= scbd_pkg::VIEW_ROWS_RST;
            cfg_reg.dest_base_offset <= scbd_pkg::DEST_BASE_RST;
            cfg_reg.dest_segment     <= scbd_pkg::DEST_SEG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/scbd_datapath.sv @@
module scbd_datapath (
    input  scbd_pkg::sprite_in_t item,
    input  scbd_pkg::view_cfg_t  cfg,
    output scbd_pkg::blit_desc_t desc
);

    logic [15:0] width_w;
    logic [15:0] half_w;
    logic [15:0] x_raw;
    logic [15:0] x_snap;
    logic [15:0] x_pix;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] edge_col;
    logic [15:0] bot_row;
    logic        in_view;

    logic [15:0] lm_raw;
    logic [15:0] lmarg;
    logic [15:0] lskip;
    logic [15:0] rmarg;
    logic [15:0] rdiff;
    logic        right_clip;
    logic [15:0] cols_fit;
    logic [15:0] cols;

    logic [15:0] tm_raw;
    logic [15:0] tmarg;
    logic [15:0] tskip;
    logic [15:0] vspan;
    logic [15:0] vdiff;
    logic        bottom_clip;
    logic [15:0] rows;

    logic [15:0] row_sum;
    logic [15:0] rowbase;
    logic [15:0] dst;
    logic [15:0] skip_bytes;
    logic [15:0] src_add;
    logic        nonempty;

    assign width_w = item.sprite_width;
    assign half_w  = {1'b0, width_w[15:1]};

    // Pixel x: left anchored, or mirrored from the right edge, then optional cell snap
    assign x_raw  = item.right_anchor
                  ? 16'(item.pos_x - {width_w[13:0], 2'b00} + item.hot_x)
                  : 16'(item.pos_x - item.hot_x);
    assign x_snap = 16'(x_raw + scbd_pkg::SNAP_BIAS) & scbd_pkg::SNAP_MASK;
    assign x_pix  = item.snap_to_cell ? x_snap : x_raw;
    assign col    = {{3{x_pix[15]}}, x_pix[15:3]};
    assign row    = 16'(item.pos_y - item.hot_y);

    // Cull against the view
    assign edge_col = 16'(col + half_w);
    assign bot_row  = 16'(row + item.sprite_height);
    assign in_view  = ($signed(row) < $signed(cfg.view_bottom))
                   && ($signed(col) < $signed(cfg.view_right))
                   && !edge_col[15]
                   && ($signed(cfg.view_left) <= $signed(edge_col))
                   && !bot_row[15]
                   && ($signed(cfg.view_top) <= $signed(bot_row));

    // Horizontal clip
    assign lm_raw     = 16'(cfg.view_left - col);
    assign lmarg      = lm_raw[15] ? 16'd0 : lm_raw;
    assign lskip      = lm_raw[15] ? 16'(-lm_raw) : 16'd0;
    assign rmarg      = 16'(cfg.view_right - col);
    assign rdiff      = 16'(rmarg - 16'(half_w + 16'd1));
    assign right_clip = rmarg[15] | rdiff[15];
    assign cols_fit   = 16'(half_w - lmarg);
    assign cols       = right_clip ? 16'(cfg.view_right - lmarg - col)
                      : (cols_fit[15] ? 16'd0 : cols_fit);

    // Vertical clip
    assign tm_raw      = 16'(cfg.view_top - row);
    assign tmarg       = tm_raw[15] ? 16'd0 : tm_raw;
    assign tskip       = tm_raw[15] ? 16'(-tm_raw) : 16'd0;
    assign vspan       = 16'(cfg.view_top + cfg.view_rows - row);
    assign vdiff       = 16'(vspan - item.sprite_height);
    assign bottom_clip = vspan[15] | vdiff[15];
    assign rows        = bottom_clip
                       ? 16'(cfg.view_top - tmarg + cfg.view_rows - row)
                       : 16'(item.sprite_height - tmarg);

    // Destination: row base from the low byte of the first drawn row
    assign row_sum = 16'(tskip + cfg.view_top);
    assign rowbase = 16'({8'd0, row_sum[7:0]} * scbd_pkg::ROW_PITCH);
    assign dst     = 16'(rowbase + cfg.dest_base_offset + lskip + cfg.view_left);

    // Source: skipped top rows (8-bit by 8-bit) plus skipped left cells
    assign skip_bytes = 16'({8'd0, tmarg[7:0]} * {8'd0, width_w[6:0], 1'b0});
    assign src_add    = 16'(skip_bytes + {lmarg[13:0], 2'b00});

    assign nonempty = ($signed(cols) > 16'sd0) && ($signed(rows) > 16'sd0)
                   && ($signed(rows) < scbd_pkg::CLIP_ROW_LIMIT);

    // Hidden or culled sprites give an all-zero descriptor
    always_comb
    begin
        desc = '0;
        if (item.visible && in_view)
        begin
            desc.drawn         = 1'b1;
            desc.src_offset    = 16'(item.src_base_offset + src_add);
            desc.src_seg_out   = item.src_segment;
            desc.dst_offset    = dst;
            desc.dst_seg_out   = cfg.dest_segment;
            desc.full_cols     = half_w[7:0];
            desc.cols_drawn    = cols;
            desc.rows_drawn    = rows;
            desc.sub_shift     = x_pix[2:0];
            desc.clip_flags    = {lmarg != 16'd0, right_clip};
            desc.clip_nonempty = nonempty;
        end
    end

endmodule

@@ src/sprite_cull_clip_blit_descriptor_unit.sv @@
// Timing: a sprite record is taken into the input register; its descriptor is computed
// combinationally in a single pass and loaded into the result register, which drives
// out_data, once the result register is empty or its transfer completes.
// Throughput: one record per cycle while the result register is free to move.
// Reset: rst_n clears both valid flags and loads the view registers with their defaults;
// records in flight are dropped.
module sprite_cull_clip_blit_descriptor_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  scbd_pkg::sprite_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output scbd_pkg::blit_desc_t  out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    scbd_pkg::view_cfg_t  cfg;
    scbd_pkg::sprite_in_t in_data_reg;
    logic                 in_valid_reg;
    scbd_pkg::blit_desc_t out_data_reg;
    scbd_pkg::blit_desc_t out_data_next;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 in_take;

    scbd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scbd_datapath u_datapath (
        .item (in_data_reg),
        .cfg  (cfg),
        .desc (out_data_next)
    );

    // Result register moves when empty or when its transfer completes
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/scbd_checker.sv @@
`include "assert_macros.svh"

module scbd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input scbd_pkg::blit_desc_t out_data
);

    logic verdict_ok;

    // Column and row counts that make up a non-empty clip
    assign verdict_ok = ($signed(out_data.cols_drawn) > 16'sd0)
                     && ($signed(out_data.rows_drawn) > 16'sd0)
                     && ($signed(out_data.rows_drawn) < scbd_pkg::CLIP_ROW_LIMIT);

    // A stalled result holds until its transfer
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Input back-pressure only when the result side is blocked
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A dropped sprite carries an all-zero descriptor
    `ASSERT_IMPLIES(a_drop_zero, clk, rst_n, out_valid && !out_data.drawn, out_data == '0)

    // A non-empty clip verdict is backed by the reported column and row counts
    `ASSERT_IMPLIES(a_verdict, clk, rst_n, out_valid && out_data.clip_nonempty, verdict_ok)

endmodule

bind sprite_cull_clip_blit_descriptor_unit scbd_checker u_scbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
